/* rtl/codc_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package codc_pkg;

    // register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 20;

    localparam logic [CFG_INDEX_W-1:0] REG_BELT_SPEED     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LONG_THRESHOLD = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_WAIT_TIMEOUT   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_BEAM_LEVEL     = 3'd4;

    // reset values of the configuration registers
    localparam logic [19:0] RST_BELT_SPEED     = 20'd25600;
    localparam logic [15:0] RST_LONG_THRESHOLD = 16'd1000;
    localparam logic [15:0] RST_MAX_LENGTH     = 16'd3000;
    localparam logic [15:0] RST_WAIT_TIMEOUT   = 16'd57;
    localparam logic        RST_BEAM_LEVEL     = 1'b0;

    // length = speed * ms / 25600 = ((speed * ms) >> 9) / 50
    // divide by 50 as multiply by ceil(2^28 / 50), exact for 22-bit operands
    localparam logic [22:0] RECIP_50 = 23'd5368710;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_ENTRY = 3'd1,
        PH_WAIT  = 3'd2,
        PH_WIDTH = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef struct packed {
        logic [19:0] belt_speed;
        logic [15:0] long_threshold;
        logic [15:0] max_length;
        logic [15:0] wait_timeout;
        logic        beam_active_level;
    } codc_cfg_t;

    typedef struct packed {
        logic [31:0] time_ms;
        logic        length_beam;
        logic        width_left_beam;
        logic        width_right_beam;
        logic        height_beam;
        logic        fire_alarm;
    } codc_sample_t;

    typedef struct packed {
        logic [15:0] length_tenths_mm;
        logic        is_long;
        logic        is_wide;
        logic        is_tall;
        logic [2:0]  category;
    } codc_result_t;

    typedef struct packed {
        logic is_wide;
        logic is_tall;
    } codc_flags_t;

endpackage

`default_nettype wire

/* rtl/codc_track.sv */
`timescale 1ns / 1ps
`default_nettype none

module codc_track #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  codc_pkg::codc_cfg_t         cfg,
    input  wire                         item_valid,
    input  codc_pkg::codc_sample_t      item,
    output logic                        item_ready,
    output logic                        meas_valid,
    output logic [TIME_WIDTH-1:0]       meas_dur,
    output codc_pkg::codc_flags_t       meas_flags,
    input  wire                         meas_ready
);

    codc_pkg::phase_t        phase_reg, phase_next;
    logic [TIME_WIDTH-1:0]   entry_time_reg, entry_time_next;
    logic [TIME_WIDTH-1:0]   release_time_reg, release_time_next;
    logic                    release_seen_reg, release_seen_next;
    logic                    tall_reg, tall_next;
    logic                    wide_reg, wide_next;

    logic                    meas_valid_reg, meas_valid_next;
    logic [TIME_WIDTH-1:0]   meas_dur_reg, meas_dur_next;
    codc_pkg::codc_flags_t   meas_flags_reg, meas_flags_next;

    logic                    process;
    logic                    emit;
    logic [TIME_WIDTH-1:0]   now;
    logic [TIME_WIDTH-1:0]   elapsed;
    logic [TIME_WIDTH-1:0]   end_time;
    logic                    len_b, left_b, right_b, high_b;

    assign item_ready = !meas_valid_reg || meas_ready;
    assign process    = item_valid && item_ready;

    assign now     = TIME_WIDTH'(item.time_ms);
    assign elapsed = now - entry_time_reg;
    assign end_time = release_seen_reg ? release_time_reg : now;

    assign len_b   = item.length_beam      == cfg.beam_active_level;
    assign left_b  = item.width_left_beam  == cfg.beam_active_level;
    assign right_b = item.width_right_beam == cfg.beam_active_level;
    assign high_b  = item.height_beam      == cfg.beam_active_level;

    always_comb
    begin
        phase_next        = phase_reg;
        entry_time_next   = entry_time_reg;
        release_time_next = release_time_reg;
        release_seen_next = release_seen_reg;
        tall_next         = tall_reg;
        wide_next         = wide_reg;
        emit              = 1'b0;

        if (process)
        begin
            if (item.fire_alarm)
            begin
                phase_next = codc_pkg::PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    codc_pkg::PH_ENTRY:
                    begin
                        if (len_b)
                        begin
                            release_time_next = now;
                            release_seen_next = 1'b1;
                        end
                        else if (release_seen_reg)
                        begin
                            // choice uses the flag as it stood before this sample
                            phase_next = wide_reg ? codc_pkg::PH_WIDTH : codc_pkg::PH_WAIT;
                        end
                        if (high_b)
                        begin
                            tall_next = 1'b1;
                        end
                        if (left_b && right_b)
                        begin
                            wide_next = 1'b1;
                        end
                    end
                    codc_pkg::PH_WAIT:
                    begin
                        if (left_b && right_b)
                        begin
                            wide_next  = 1'b1;
                            phase_next = codc_pkg::PH_WIDTH;
                        end
                        // timeout wins over a width pair in the same sample
                        if (elapsed > TIME_WIDTH'(cfg.wait_timeout))
                        begin
                            phase_next = codc_pkg::PH_DONE;
                        end
                    end
                    codc_pkg::PH_WIDTH:
                    begin
                        if (!left_b && !right_b)
                        begin
                            phase_next = codc_pkg::PH_DONE;
                        end
                    end
                    codc_pkg::PH_DONE:
                    begin
                        emit       = 1'b1;
                        phase_next = codc_pkg::PH_IDLE;
                    end
                    default:
                    begin
                        if (len_b)
                        begin
                            entry_time_next   = now;
                            release_time_next = '0;
                            release_seen_next = 1'b0;
                            tall_next         = 1'b0;
                            wide_next         = 1'b0;
                            phase_next        = codc_pkg::PH_ENTRY;
                        end
                        else
                        begin
                            phase_next = codc_pkg::PH_IDLE;
                        end
                    end
                endcase
            end
        end
    end

    always_comb
    begin
        meas_valid_next = meas_valid_reg;
        meas_dur_next   = meas_dur_reg;
        meas_flags_next = meas_flags_reg;
        if (meas_ready)
        begin
            meas_valid_next = 1'b0;
        end
        if (emit)
        begin
            meas_valid_next         = 1'b1;
            meas_dur_next           = end_time - entry_time_reg;
            meas_flags_next.is_wide = wide_reg;
            meas_flags_next.is_tall = tall_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= codc_pkg::PH_IDLE;
            entry_time_reg   <= '0;
            release_time_reg <= '0;
            release_seen_reg <= 1'b0;
            tall_reg         <= 1'b0;
            wide_reg         <= 1'b0;
            meas_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            entry_time_reg   <= entry_time_next;
            release_time_reg <= release_time_next;
            release_seen_reg <= release_seen_next;
            tall_reg         <= tall_next;
            wide_reg         <= wide_next;
            meas_valid_reg   <= meas_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        meas_dur_reg   <= meas_dur_next;
        meas_flags_reg <= meas_flags_next;
    end

    assign meas_valid = meas_valid_reg;
    assign meas_dur   = meas_dur_reg;
    assign meas_flags = meas_flags_reg;

    a_done_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (process && !item.fire_alarm && phase_reg == codc_pkg::PH_DONE)
            |=> (phase_reg == codc_pkg::PH_IDLE && meas_valid_reg))
        else $error("done phase did not emit and return to idle");

    a_emit_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(meas_valid_reg) |-> $past(phase_reg == codc_pkg::PH_DONE))
        else $error("measurement appeared outside the done phase");

    a_entry_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == codc_pkg::PH_ENTRY && $past(phase_reg != codc_pkg::PH_ENTRY))
            |-> $past(phase_reg == codc_pkg::PH_IDLE))
        else $error("entry phase reached from a phase other than idle");

endmodule

`default_nettype wire

/* rtl/codc_len.sv */
`timescale 1ns / 1ps
`default_nettype none

module codc_len #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  codc_pkg::codc_cfg_t         cfg,
    input  wire                         meas_valid,
    input  wire [TIME_WIDTH-1:0]        meas_dur,
    input  codc_pkg::codc_flags_t       meas_flags,
    output logic                        meas_ready,
    output logic                        result_valid,
    output codc_pkg::codc_result_t      result,
    input  wire                         result_stall
);

    // stage A: speed * duration
    logic                    prod_valid_reg, prod_valid_next;
    logic [30:0]             prod_reg;
    logic                    sat_reg;
    codc_pkg::codc_flags_t   flags_reg;

    // stage B: result register
    logic                    res_valid_reg, res_valid_next;
    codc_pkg::codc_result_t  res_reg;

    logic                    out_ready;
    logic                    a_load;
    logic                    b_load;

    logic [63:0]             dur_ext;
    logic                    dur_hi;
    logic [50:0]             prod;
    logic                    speed_nz;
    logic                    sat;

    logic [44:0]             quot_prod;
    logic [16:0]             quot;
    logic [15:0]             len;
    logic                    is_long;

    assign out_ready  = !res_valid_reg || !result_stall;
    assign meas_ready = !prod_valid_reg || out_ready;
    assign a_load     = meas_valid && meas_ready;
    assign b_load     = prod_valid_reg && out_ready;

    // any product at or above 2^31 is past the largest max_length
    assign dur_ext  = 64'(meas_dur);
    assign dur_hi   = |dur_ext[63:31];
    assign prod     = 51'(cfg.belt_speed) * 51'(dur_ext[30:0]);
    assign speed_nz = |cfg.belt_speed;
    assign sat      = speed_nz && (dur_hi || (|prod[50:31]));

    assign quot_prod = 45'(prod_reg[30:9]) * 45'(codc_pkg::RECIP_50);
    assign quot      = quot_prod[44:28];
    assign len       = (sat_reg || quot > 17'(cfg.max_length)) ? cfg.max_length : quot[15:0];
    assign is_long   = len >= cfg.long_threshold;

    always_comb
    begin
        prod_valid_next = prod_valid_reg;
        if (out_ready)
        begin
            prod_valid_next = 1'b0;
        end
        if (a_load)
        begin
            prod_valid_next = 1'b1;
        end

        res_valid_next = res_valid_reg;
        if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
        if (b_load)
        begin
            res_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            prod_valid_reg <= prod_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_load)
        begin
            prod_reg  <= prod[30:0];
            sat_reg   <= sat;
            flags_reg <= meas_flags;
        end
        if (b_load)
        begin
            res_reg.length_tenths_mm <= len;
            res_reg.is_long          <= is_long;
            res_reg.is_wide          <= flags_reg.is_wide;
            res_reg.is_tall          <= flags_reg.is_tall;
            res_reg.category         <= {is_long, flags_reg.is_wide, flags_reg.is_tall};
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    a_len_capped: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.length_tenths_mm <= cfg.max_length))
        else $error("reported length above saturation limit");

    a_zero_speed: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && cfg.belt_speed == '0) |-> (result.length_tenths_mm == '0))
        else $error("nonzero length with belt stopped");

    a_prod_held: assert property (@(posedge clk) disable iff (!rst_n)
        (prod_valid_reg && !out_ready) |=> (prod_valid_reg && $stable(prod_reg)))
        else $error("product stage lost its transaction while blocked");

endmodule

`default_nettype wire

/* rtl/conveyor_object_dimension_classifier_core.sv */
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                  Payload
// sample    sample_valid/sample_stall  sample (codc_sample_t)
// result    result_valid/result_stall  result (codc_result_t)
// cfg       cfg_valid/cfg_ready        cfg_index, cfg_data
//
// One sample per cycle sustained while result_stall is low. A sample is registered and
// runs the phase machine; a finished measurement then takes the speed*duration multiply,
// then a reciprocal multiply (/25600 and saturation) to reach the result register.
// Reset clears the phase machine, all valid bits and loads the register defaults.
// result_stall only backs up the pipeline once every stage holds a transaction.

module conveyor_object_dimension_classifier_core #(
    parameter int unsigned TIME_WIDTH = 32
) (
    input  wire                                      clk,
    input  wire                                      rst_n,
    input  wire                                      sample_valid,
    output logic                                     sample_stall,
    input  codc_pkg::codc_sample_t                   sample,
    output logic                                     result_valid,
    input  wire                                      result_stall,
    output codc_pkg::codc_result_t                   result,
    input  wire                                      cfg_valid,
    output logic                                     cfg_ready,
    input  wire [codc_pkg::CFG_INDEX_W-1:0]          cfg_index,
    input  wire [codc_pkg::CFG_DATA_W-1:0]           cfg_data
);

    codc_pkg::codc_cfg_t     cfg_reg, cfg_next;

    logic                    smp_valid_reg, smp_valid_next;
    codc_pkg::codc_sample_t  smp_reg;
    logic                    smp_load;
    logic                    item_ready;

    logic                    meas_valid;
    logic [TIME_WIDTH-1:0]   meas_dur;
    codc_pkg::codc_flags_t   meas_flags;
    logic                    meas_ready;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                codc_pkg::REG_BELT_SPEED:     cfg_next.belt_speed        = cfg_data;
                codc_pkg::REG_LONG_THRESHOLD: cfg_next.long_threshold    = cfg_data[15:0];
                codc_pkg::REG_MAX_LENGTH:     cfg_next.max_length        = cfg_data[15:0];
                codc_pkg::REG_WAIT_TIMEOUT:   cfg_next.wait_timeout      = cfg_data[15:0];
                codc_pkg::REG_BEAM_LEVEL:     cfg_next.beam_active_level = cfg_data[0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.belt_speed        <= codc_pkg::RST_BELT_SPEED;
            cfg_reg.long_threshold    <= codc_pkg::RST_LONG_THRESHOLD;
            cfg_reg.max_length        <= codc_pkg::RST_MAX_LENGTH;
            cfg_reg.wait_timeout      <= codc_pkg::RST_WAIT_TIMEOUT;
            cfg_reg.beam_active_level <= codc_pkg::RST_BEAM_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // input register
    assign sample_stall = smp_valid_reg && !item_ready;
    assign smp_load     = sample_valid && !sample_stall;

    always_comb
    begin
        smp_valid_next = smp_valid_reg;
        if (item_ready)
        begin
            smp_valid_next = 1'b0;
        end
        if (smp_load)
        begin
            smp_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smp_valid_reg <= 1'b0;
        end
        else
        begin
            smp_valid_reg <= smp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_load)
        begin
            smp_reg <= sample;
        end
    end

    codc_track #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_track (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (smp_valid_reg),
        .item       (smp_reg),
        .item_ready (item_ready),
        .meas_valid (meas_valid),
        .meas_dur   (meas_dur),
        .meas_flags (meas_flags),
        .meas_ready (meas_ready)
    );

    codc_len #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_len (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .meas_valid   (meas_valid),
        .meas_dur     (meas_dur),
        .meas_flags   (meas_flags),
        .meas_ready   (meas_ready),
        .result_valid (result_valid),
        .result       (result),
        .result_stall (result_stall)
    );

endmodule

`default_nettype wire
